FILE: rtl/des_block_encrypt_core_macros.svh
// Assertion macros for the DES core checker
`ifndef DES_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define DES_BLOCK_ENCRYPT_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define DES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/des_pkg.sv
`timescale 1ns / 1ps
package des_pkg;

  localparam int unsigned BlockW   = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned KeyHalfW = 28;
  localparam int unsigned RoundKeyW = 48;
  localparam int unsigned NumRounds = 16;
  localparam int unsigned DefRoundsPerStage = 1;

  typedef logic [BlockW-1:0]    block_t;
  typedef logic [HalfW-1:0]     half_t;
  typedef logic [KeyHalfW-1:0]  khalf_t;
  typedef logic [RoundKeyW-1:0] rkey_t;

  // Round-stage payload: halves plus the key halves after this round's rotate
  typedef struct packed {
    half_t  l;
    half_t  r;
    khalf_t c;
    khalf_t d;
  } rnd_data_t;

  typedef logic [5:0] tab6_t;

  function automatic logic [1:0] shift_amt(input logic [3:0] rnd);
    case (rnd)
      4'd0, 4'd1, 4'd8, 4'd15: shift_amt = 2'd1;
      default:                 shift_amt = 2'd2;
    endcase
  endfunction

  function automatic khalf_t rot28(input khalf_t v, input logic [1:0] s);
    rot28 = (s == 2'd1) ? {v[KeyHalfW-2:0], v[KeyHalfW-1]}
                        : {v[KeyHalfW-3:0], v[KeyHalfW-1:KeyHalfW-2]};
  endfunction

  // Generic bit selection: DES position p (1 = MSB of a w-bit word)
  function automatic block_t ip_perm(input block_t s);
    localparam int T [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    block_t r;
    r = '0;
    for (int i = 0; i < 64; i++) r[63-i] = s[64-T[i]];
    return r;
  endfunction

  function automatic block_t fp_perm(input block_t s);
    localparam int T [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    block_t r;
    r = '0;
    for (int i = 0; i < 64; i++) r[63-i] = s[64-T[i]];
    return r;
  endfunction

  function automatic logic [55:0] pc1_perm(input block_t s);
    localparam int T [56] = '{
      57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
      10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29,  21,13,5,28,20,12,4};
    logic [55:0] r;
    r = '0;
    for (int i = 0; i < 56; i++) r[55-i] = s[64-T[i]];
    return r;
  endfunction

  function automatic rkey_t pc2_perm(input logic [55:0] s);
    localparam int T [48] = '{
      14,17,11,24,1,5,   3,28,15,6,21,10,
      23,19,12,4,26,8,   16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48,
      44,49,39,56,34,53, 46,42,50,36,29,32};
    rkey_t r;
    r = '0;
    for (int i = 0; i < 48; i++) r[47-i] = s[56-T[i]];
    return r;
  endfunction

  function automatic rkey_t e_perm(input half_t s);
    localparam int T [48] = '{
      32,1,2,3,4,5,     4,5,6,7,8,9,
      8,9,10,11,12,13,  12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25,
      24,25,26,27,28,29, 28,29,30,31,32,1};
    rkey_t r;
    r = '0;
    for (int i = 0; i < 48; i++) r[47-i] = s[32-T[i]];
    return r;
  endfunction

  function automatic half_t p_perm(input half_t s);
    localparam int T [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    half_t r;
    r = '0;
    for (int i = 0; i < 32; i++) r[31-i] = s[32-T[i]];
    return r;
  endfunction

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic half_t feistel(input half_t r, input rkey_t k);
    rkey_t x;
    half_t s;
    tab6_t six;
    x = e_perm(r) ^ k;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    return p_perm(s);
  endfunction

endpackage

FILE: rtl/des_stream_if.sv
`timescale 1ns / 1ps
interface des_stream_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/des_block_encrypt_core.sv
`timescale 1ns / 1ps
// DES encryptor (FIPS 46-3), 64-bit blocks, key from the cfg write channel.
// Seventeen register stages: an entry stage holding IP(block) and PC-1(key),
// then one stage per Feistel round; the final permutation is wiring on the
// last stage. A request is taken every cycle while the pipe is not halted.
// The whole pipe advances together and halts while the result is held
// unaccepted with a full last stage, so nothing is lost or repeated. The key
// is sampled per request at entry, so a key write changes only requests
// accepted after it.
module des_block_encrypt_core import des_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  des_stream_if.sink   in_ch,
  des_stream_if.source out_ch,
  des_stream_if.sink   cfg_ch
);
  localparam int unsigned NStg = NumRounds + 1;

  block_t    key_r;
  logic      en;
  logic      vld   [NStg];
  rnd_data_t dat   [NStg];
  logic      vld0_r;
  rnd_data_t dat0_r;
  block_t    ip_blk;
  logic [55:0] cd;

  // Key register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_ch.valid) begin
      key_r <= cfg_ch.data;
    end
  end

  // Global advance: move when the output slot is empty or being drained
  assign en          = !vld[NStg-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign ip_blk = ip_perm(in_ch.data);
  assign cd     = pc1_perm(key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat0_r <= '{l: ip_blk[63:32], r: ip_blk[31:0], c: cd[55:28], d: cd[27:0]};
    end
  end

  assign vld[0] = vld0_r;
  assign dat[0] = dat0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    des_round #(.Rnd(4'(g))) u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[g]),
      .d_in    (dat[g]),
      .vld_out (vld[g+1]),
      .d_out   (dat[g+1])
    );
  end

  // Halves swap before the final permutation
  assign out_ch.valid = vld[NStg-1];
  assign out_ch.data  = fp_perm({dat[NStg-1].r, dat[NStg-1].l});
endmodule

FILE: rtl/des_round.sv
`timescale 1ns / 1ps
// One Feistel round with its key-schedule rotate, registered at the output.
module des_round import des_pkg::*; #(
  parameter logic [3:0] Rnd = 4'd0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_in,
  input  rnd_data_t d_in,
  output logic      vld_out,
  output rnd_data_t d_out
);
  rnd_data_t d_nxt, d_r;
  logic      vld_r;
  khalf_t    c_rot, d_rot;

  always_comb begin
    c_rot = rot28(d_in.c, shift_amt(Rnd));
    d_rot = rot28(d_in.d, shift_amt(Rnd));
    d_nxt.c = c_rot;
    d_nxt.d = d_rot;
    d_nxt.l = d_in.r;
    d_nxt.r = d_in.l ^ feistel(d_in.r, pc2_perm({c_rot, d_rot}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;
endmodule

FILE: rtl/des_block_encrypt_core_chk.sv
`timescale 1ns / 1ps
`include "des_block_encrypt_core_macros.svh"
module des_block_encrypt_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data
);
  `DES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
  `DES_ASSERT_IMPL(a_in_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")
  `DES_ASSERT_IMPL(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while pipe stalled")
endmodule

bind des_block_encrypt_core des_block_encrypt_core_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
